@@ src/pds_pkg.sv @@
// Shared widths, pipeline timing, saturation limits and register indexes for the drift pipeline.
package pds_pkg;

	// Word format: signed fixed point, FB fraction bits in W bits
	localparam int W       = 64;
	localparam int FB      = 40;
	localparam int HW      = W / 2;
	localparam int LEN_W   = W - 1;
	localparam int BETA_W  = FB + 1;

	// Square root yields one result bit a stage, division one quotient bit a stage
	localparam int SQ      = (W + FB) / 2;
	localparam int DV      = W - 1 + FB;
	localparam int MUL_LAT = 4;

	localparam logic signed [W-1:0] S_MAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] S_MIN  = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] FX_ONE = W'(1) << FB;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd2;

	localparam logic MODE_EXPANDED = 1'b0;
	localparam logic MODE_EXACT    = 1'b1;

	// Stage at which each intermediate lands, counted from the input register (stage 0)
	localparam int T_SQ   = 2 * MUL_LAT;
	localparam int T_TS   = T_SQ + 2;
	localparam int T_G1   = T_TS + MUL_LAT;
	localparam int T_SO   = T_G1 + 1 + MUL_LAT;
	localparam int T_SQX  = 1 + MUL_LAT;
	localparam int T_ARG  = T_SQX + 2;
	localparam int T_ROOT = T_ARG + SQ;
	localparam int T_QUO  = T_ROOT + DV;
	localparam int T_OFS  = T_QUO + MUL_LAT;
	localparam int T_ADD  = T_OFS + 1;
	localparam int T_OUT  = T_ADD + 1;
	localparam int T_C1   = 2 * MUL_LAT + 1;

endpackage

@@ src/particle_drift_step.sv @@
// Top level of the drift pipeline: field-free drift of one particle per transaction.
//
//  channel   direction  payload
//  s_axis    in         tdata: pos_x, pos_y, mom_x, mom_y, long_sigma, path_pos,
//                              recip_rel_mom, recip_rel_vel, mom_dev, energy_dev
//  m_axis    out        tdata: new_x, new_y, new_sigma, new_s; tuser: lost
//  cfg       in         cfg_index selects drift_mode, drift_length, reference_beta
//
//  One particle enters per cycle unless the output is stalled. The pipeline depth
//  is set by the square root (one root bit a stage) followed by the divider
//  (one quotient bit a stage).
//  A stalled output freezes every stage at once, so nothing is lost or repeated.
//  Reset clears the valid bits and loads the register reset values.
module particle_drift_step import pds_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// pos_x, pos_y, mom_x, mom_y, long_sigma, path_pos, recip_rel_mom,
	// recip_rel_vel, mom_dev, energy_dev (64 bits each, lowest first)
	input  logic [10*W-1:0]      s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// new_x, new_y, new_sigma, new_s (64 bits each, lowest first)
	output logic [4*W-1:0]       m_axis_tdata,
	// lost
	output logic                 m_axis_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]         cfg_data
);

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
	                                                input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_add = s[W] ? S_MIN : S_MAX;
		end else begin
			sat_add = s[W-1:0];
		end
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
	                                                input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_sub = s[W] ? S_MIN : S_MAX;
		end else begin
			sat_sub = s[W-1:0];
		end
	endfunction

	// ---------------- configuration ----------------
	logic              mode_q;
	logic [LEN_W-1:0]  len_q;
	logic [BETA_W-1:0] beta_q;
	logic signed [W-1:0] len64, beta64;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EXPANDED;
			len_q  <= '0;
			beta_q <= BETA_W'(1) << FB;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[0];
				REG_LENGTH: len_q  <= cfg_data[LEN_W-1:0];
				REG_BETA:   beta_q <= cfg_data[BETA_W-1:0];
				default:    ;
			endcase
		end
	end

	assign len64  = W'(len_q);
	assign beta64 = W'(beta_q);

	// ---------------- flow control ----------------
	// All stages advance together; hold everything while the output waits
	logic           en;
	logic [T_OUT:0] vld_q;

	assign en            = ~vld_q[T_OUT] | m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[T_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[T_OUT-1:0], s_axis_tvalid};
		end
	end

	// ---------------- stage 0: input register ----------------
	logic [10*W-1:0] in_s0;
	logic signed [W-1:0] x0, y0, px0, py0, sig0, s0, rpp0, rvv0, dlt0, psg0;

	always_ff @(posedge clk) begin
		if (en) begin
			in_s0 <= s_axis_tdata;
		end
	end

	assign x0   = in_s0[0*W +: W];
	assign y0   = in_s0[1*W +: W];
	assign px0  = in_s0[2*W +: W];
	assign py0  = in_s0[3*W +: W];
	assign sig0 = in_s0[4*W +: W];
	assign s0   = in_s0[5*W +: W];
	assign rpp0 = in_s0[6*W +: W];
	assign rvv0 = in_s0[7*W +: W];
	assign dlt0 = in_s0[8*W +: W];
	assign psg0 = in_s0[9*W +: W];

	// ---------------- delay lines ----------------
	logic [4*W-1:0] base_q [T_ADD];
	logic [2*W-1:0] pxy_q  [T_QUO];
	logic [W-1:0]   rvv_q  [T_TS];
	logic [W-1:0]   psg_q  [MUL_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			base_q[0] <= {s0, sig0, y0, x0};
			pxy_q[0]  <= {py0, px0};
			rvv_q[0]  <= rvv0;
			psg_q[0]  <= psg0;
			for (int i = 1; i < T_ADD; i++)   base_q[i] <= base_q[i-1];
			for (int i = 1; i < T_QUO; i++)   pxy_q[i]  <= pxy_q[i-1];
			for (int i = 1; i < T_TS; i++)    rvv_q[i]  <= rvv_q[i-1];
			for (int i = 1; i < MUL_LAT; i++) psg_q[i]  <= psg_q[i-1];
		end
	end

	// ---------------- expanded (paraxial) path ----------------
	logic signed [W-1:0] spx, spy, sqx, sqy, xoe, yoe, g1, soe;
	logic signed [W-1:0] sq_s9, ts_s10, gain_s15;

	pds_mul u_spx (.clk(clk), .en(en), .a(px0), .b(rpp0), .p(spx));
	pds_mul u_spy (.clk(clk), .en(en), .a(py0), .b(rpp0), .p(spy));
	pds_mul u_sqx (.clk(clk), .en(en), .a(spx), .b(spx),  .p(sqx));
	pds_mul u_sqy (.clk(clk), .en(en), .a(spy), .b(spy),  .p(sqy));
	pds_mul u_xoe (.clk(clk), .en(en), .a(spx), .b(len64), .p(xoe));
	pds_mul u_yoe (.clk(clk), .en(en), .a(spy), .b(len64), .p(yoe));

	// 1 + (px'^2 + py'^2)/2, halving by floor
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s9    <= sat_add(sqx, sqy);
			ts_s10   <= sat_add(FX_ONE, sq_s9 >>> 1);
			gain_s15 <= sat_sub(FX_ONE, g1);
		end
	end

	pds_mul u_g1  (.clk(clk), .en(en), .a(rvv_q[T_TS-1]), .b(ts_s10), .p(g1));
	pds_mul u_soe (.clk(clk), .en(en), .a(len64), .b(gain_s15), .p(soe));

	// Park the early x and y offsets until the sigma term is ready
	logic [2*W-1:0] xye_q [T_SO - T_SQ];
	logic [3*W-1:0] exp_q [T_OFS - T_SO];

	always_ff @(posedge clk) begin
		if (en) begin
			xye_q[0] <= {yoe, xoe};
			for (int i = 1; i < T_SO - T_SQ; i++) xye_q[i] <= xye_q[i-1];
			exp_q[0] <= {soe, xye_q[T_SO-T_SQ-1]};
			for (int i = 1; i < T_OFS - T_SO; i++) exp_q[i] <= exp_q[i-1];
		end
	end

	// ---------------- exact path ----------------
	logic signed [W-1:0] px1, py1, pxq, pyq;
	logic signed [W-1:0] opd_s1, oo, pxx, pyy, a1_s6, pyy_s6, arg_s7;
	logic signed [W-1:0] b2, bp, c1_s9;
	logic [SQ-1:0]       root;
	logic signed [W-1:0] lpz, xox, yox, lbz;
	logic                lost_now;

	assign px1 = pxy_q[0][W-1:0];
	assign py1 = pxy_q[0][2*W-1:W];
	assign pxq = pxy_q[T_QUO-1][W-1:0];
	assign pyq = pxy_q[T_QUO-1][2*W-1:W];

	always_ff @(posedge clk) begin
		if (en) begin
			opd_s1 <= sat_add(FX_ONE, dlt0);
			a1_s6  <= sat_sub(oo, pxx);
			pyy_s6 <= pyy;
			arg_s7 <= sat_sub(a1_s6, pyy_s6);
			c1_s9  <= sat_add(bp, FX_ONE);
		end
	end

	pds_mul u_oo  (.clk(clk), .en(en), .a(opd_s1), .b(opd_s1), .p(oo));
	pds_mul u_pxx (.clk(clk), .en(en), .a(px1), .b(px1), .p(pxx));
	pds_mul u_pyy (.clk(clk), .en(en), .a(py1), .b(py1), .p(pyy));
	pds_mul u_b2  (.clk(clk), .en(en), .a(beta64), .b(beta64), .p(b2));
	pds_mul u_bp  (.clk(clk), .en(en), .a(b2), .b(psg_q[MUL_LAT-1]), .p(bp));

	// In exact mode, a root argument that is not positive marks the particle lost
	assign lost_now = (mode_q == MODE_EXACT) & (arg_s7[W-1] | (arg_s7 == '0));

	pds_sqrt u_sqrt (.clk(clk), .en(en), .arg(arg_s7[W-2:0]), .root(root));
	pds_div  u_div  (.clk(clk), .en(en), .num(len_q), .den(root), .quo(lpz));

	logic [W-1:0] c1_q   [T_QUO - T_C1];
	logic         lost_q [T_OFS - T_ARG];

	always_ff @(posedge clk) begin
		if (en) begin
			c1_q[0]   <= c1_s9;
			lost_q[0] <= lost_now;
			for (int i = 1; i < T_QUO - T_C1; i++)  c1_q[i]   <= c1_q[i-1];
			for (int i = 1; i < T_OFS - T_ARG; i++) lost_q[i] <= lost_q[i-1];
		end
	end

	pds_mul u_xox (.clk(clk), .en(en), .a(pxq), .b(lpz), .p(xox));
	pds_mul u_yox (.clk(clk), .en(en), .a(pyq), .b(lpz), .p(yox));
	pds_mul u_lbz (.clk(clk), .en(en), .a(c1_q[T_QUO-T_C1-1]), .b(lpz), .p(lbz));

	// ---------------- offset select and final sums ----------------
	logic signed [W-1:0] add_x_q, add_y_q, add_sig_q;
	logic                lost_add_q;
	logic [3*W-1:0]      exp_t;
	logic signed [W-1:0] bx, by, bsig, bs;
	logic [4*W-1:0]      out_q;
	logic                lost_out_q;

	assign exp_t = exp_q[T_OFS-T_SO-1];

	always_ff @(posedge clk) begin
		if (en) begin
			lost_add_q <= lost_q[T_OFS-T_ARG-1];
			if (mode_q == MODE_EXACT) begin
				add_x_q   <= xox;
				add_y_q   <= yox;
				add_sig_q <= sat_sub(len64, lbz);
			end else begin
				add_x_q   <= exp_t[W-1:0];
				add_y_q   <= exp_t[2*W-1:W];
				add_sig_q <= exp_t[3*W-1:2*W];
			end
		end
	end

	assign bx   = base_q[T_ADD-1][0*W +: W];
	assign by   = base_q[T_ADD-1][1*W +: W];
	assign bsig = base_q[T_ADD-1][2*W +: W];
	assign bs   = base_q[T_ADD-1][3*W +: W];

	// Lost particles pass through unchanged
	always_ff @(posedge clk) begin
		if (en) begin
			lost_out_q <= lost_add_q;
			if (lost_add_q) begin
				out_q <= {bs, bsig, by, bx};
			end else begin
				out_q <= {sat_add(bs, len64), sat_add(bsig, add_sig_q),
				          sat_add(by, add_y_q), sat_add(bx, add_x_q)};
			end
		end
	end

	assign m_axis_tdata = out_q;
	assign m_axis_tuser = lost_out_q;

	// ---------------- checks ----------------
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[T_OUT] && !m_axis_tready |=> $stable(vld_q))
		else $error("pipeline moved while the output was stalled");

	a_lost_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> mode_q == MODE_EXACT)
		else $error("lost flag raised in expanded mode");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input refused with an empty output stage");

endmodule

@@ src/pds_mul.sv @@
// Four-stage fixed-point multiplier: floor of the product over 2^FB, saturated.
module pds_mul import pds_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] p
);

	localparam int PW = 2 * W;
	localparam int RW = PW - FB;

	logic [W-1:0]    ua, ub;
	logic [W-1:0]    ma_s1, mb_s1;
	logic            neg_s1, neg_s2, neg_s3;
	logic [2*HW-1:0] ll_s2, lh_s2, hl_s2, hh_s2;
	logic [PW-1:0]   prod_s3;
	logic [RW-1:0]   r;
	logic            over;

	assign ua = a;
	assign ub = b;

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= a[W-1] ? (~ua + 1'b1) : ua;
			mb_s1  <= b[W-1] ? (~ub + 1'b1) : ub;
			neg_s1 <= a[W-1] ^ b[W-1];
			ll_s2  <= ma_s1[HW-1:0] * mb_s1[HW-1:0];
			lh_s2  <= ma_s1[HW-1:0] * mb_s1[W-1:HW];
			hl_s2  <= ma_s1[W-1:HW] * mb_s1[HW-1:0];
			hh_s2  <= ma_s1[W-1:HW] * mb_s1[W-1:HW];
			neg_s2 <= neg_s1;
			prod_s3 <= {hh_s2, ll_s2} + (PW'(lh_s2) << HW) + (PW'(hl_s2) << HW);
			neg_s3  <= neg_s2;
		end
	end

	// Round toward minus infinity: bump the magnitude of a negative product with a remainder
	always_comb begin
		r = prod_s3[PW-1:FB] + RW'(neg_s3 & (|prod_s3[FB-1:0]));
		if (neg_s3) begin
			over = (|r[RW-1:W]) | (r[W-1] & (|r[W-2:0]));
		end else begin
			over = |r[RW-1:W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (over) begin
				p <= neg_s3 ? S_MIN : S_MAX;
			end else begin
				p <= neg_s3 ? (~r[W-1:0] + 1'b1) : r[W-1:0];
			end
		end
	end

endmodule

@@ src/pds_sqrt.sv @@
// Pipelined digit-by-digit square root of arg * 2^FB, one root bit per stage.
module pds_sqrt import pds_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [W-2:0]     arg,
	output logic [SQ-1:0]    root
);

	localparam int RADW = 2 * SQ;
	localparam int RMW  = SQ + 3;

	logic [RADW-1:0] rad_q  [SQ];
	logic [SQ-1:0]   root_q [SQ];
	logic [RMW-1:0]  rem_q  [SQ];

	for (genvar k = 0; k < SQ; k++) begin : g_step
		logic [RADW-1:0] rad_i;
		logic [SQ-1:0]   root_i;
		logic [RMW-1:0]  rem_i, rem_t, trial;

		if (k == 0) begin : g_first
			assign rad_i  = RADW'({arg, {FB{1'b0}}});
			assign root_i = '0;
			assign rem_i  = '0;
		end else begin : g_next
			assign rad_i  = rad_q[k-1];
			assign root_i = root_q[k-1];
			assign rem_i  = rem_q[k-1];
		end

		// Bring down the next two radicand bits and try 4r+1
		assign rem_t = {rem_i[RMW-3:0], rad_i[RADW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k] <= rad_i << 2;
				if (rem_t >= trial) begin
					rem_q[k]  <= rem_t - trial;
					root_q[k] <= {root_i[SQ-2:0], 1'b1};
				end else begin
					rem_q[k]  <= rem_t;
					root_q[k] <= {root_i[SQ-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_q[SQ-1];

endmodule

@@ src/pds_div.sv @@
// Pipelined restoring divider: (num * 2^FB) / den, one quotient bit per stage, saturated.
module pds_div import pds_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [LEN_W-1:0]    num,
	input  logic [SQ-1:0]       den,
	output logic signed [W-1:0] quo
);

	logic [DV-1:0] num_q [DV];
	logic [SQ-1:0] den_q [DV];
	logic [SQ-1:0] rem_q [DV];
	logic [DV-1:0] quo_q [DV];
	logic [DV-1:0] q;

	for (genvar k = 0; k < DV; k++) begin : g_step
		logic [DV-1:0] num_i, quo_i;
		logic [SQ-1:0] den_i, rem_i;
		logic [SQ:0]   rem_t, diff;

		if (k == 0) begin : g_first
			assign num_i = {num, {FB{1'b0}}};
			assign den_i = den;
			assign rem_i = '0;
			assign quo_i = '0;
		end else begin : g_next
			assign num_i = num_q[k-1];
			assign den_i = den_q[k-1];
			assign rem_i = rem_q[k-1];
			assign quo_i = quo_q[k-1];
		end

		assign rem_t = {rem_i, num_i[DV-1]};
		assign diff  = rem_t - {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k] <= num_i << 1;
				den_q[k] <= den_i;
				if (rem_t >= {1'b0, den_i}) begin
					rem_q[k] <= diff[SQ-1:0];
					quo_q[k] <= {quo_i[DV-2:0], 1'b1};
				end else begin
					rem_q[k] <= rem_t[SQ-1:0];
					quo_q[k] <= {quo_i[DV-2:0], 1'b0};
				end
			end
		end
	end

	assign q   = quo_q[DV-1];
	assign quo = (|q[DV-1:W-1]) ? S_MAX : {1'b0, q[W-2:0]};

endmodule

@@ verif/tb_particle_drift_step.sv @@
// Self-checking testbench for particle_drift_step: directed table plus random particle traffic.
module tb_particle_drift_step;
	import pds_pkg::*;

	localparam int  WATCHDOG_LIMIT = 5000;
	localparam int  HOLD_CYCLES    = 400;
	localparam int  SETTLE_CYCLES  = 200;
	localparam int  PHASES         = 9;
	localparam int  PHASE_ITEMS    = 148;
	localparam logic [W-1:0] BETA_ALL = 64'h1FF_FFFF_FFFF;
	localparam logic [W-1:0] LEN_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	// index past the end of the register list
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef logic signed [W-1:0] word_t;
	typedef word_t particle_t [10];

	typedef struct {
		word_t coord [4];
		logic  lost;
	} drift_result_t;

	typedef struct {
		logic      mode;
		word_t     len;
		word_t     beta;
		particle_t p;
		bit        typed;	// expectation is the unchanged coordinates
		logic      lost;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [10*W-1:0]      s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [4*W-1:0]       m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [W-1:0]         cfg_data = '0;

	// shadow copy of the drift registers, updated on each write transaction
	logic  sh_mode = MODE_EXPANDED;
	word_t sh_len  = '0;
	word_t sh_beta = FX_ONE;

	drift_result_t pending_drifts [$];
	stim_row_t     stim_rows [$];
	int  errors = 0;
	int  results_seen = 0;
	int  lost_seen = 0;
	int  items_sent = 0;
	int  idle_cycles = 0;
	bit  hold_req = 1'b0;
	bit  no_gaps = 1'b0;

	particle_drift_step u_top (.*);

	always #5 clk = ~clk;

	// ---------------- fixed-point predictor ----------------

	function automatic word_t clamp(logic signed [129:0] v);
		logic signed [129:0] hi, lo;
		hi = S_MAX;
		lo = S_MIN;
		if (v > hi) return S_MAX;
		if (v < lo) return S_MIN;
		return word_t'(v);
	endfunction

	function automatic word_t qadd(word_t a, word_t b);
		logic signed [129:0] wa, wb;
		wa = a;
		wb = b;
		return clamp(wa + wb);
	endfunction

	function automatic word_t qsub(word_t a, word_t b);
		logic signed [129:0] wa, wb;
		wa = a;
		wb = b;
		return clamp(wa - wb);
	endfunction

	// product floored after dropping the fraction bits
	function automatic word_t qmul(word_t a, word_t b);
		logic signed [129:0] wa, wb;
		wa = a;
		wb = b;
		return clamp((wa * wb) >>> FB);
	endfunction

	// quotient truncated toward zero; a zero divisor saturates by the dividend's sign
	function automatic word_t qdiv(word_t a, word_t b);
		logic signed [129:0] wa, wb;
		wa = a;
		wb = b;
		if (b == 0) begin
			if (a == 0) return '0;
			return (a > 0) ? S_MAX : S_MIN;
		end
		return clamp((wa <<< FB) / wb);
	endfunction

	function automatic word_t qsqrt(word_t a);
		logic [127:0] v, c2;
		logic [63:0]  r, c;
		if (a <= 0) return '0;
		v = {64'b0, a} << FB;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c  = r | (64'b1 << i);
			c2 = {64'b0, c} * {64'b0, c};
			if (c2 <= v) r = c;
		end
		return word_t'(r);
	endfunction

	function automatic drift_result_t drift_particle(particle_t p);
		drift_result_t r;
		word_t spx, spy, sq, gain, opd, arg, lpz, b2, lbz;
		r.coord = '{p[0], p[1], p[4], p[5]};
		r.lost  = 1'b0;
		if (sh_mode == MODE_EXPANDED) begin
			spx  = qmul(p[2], p[6]);
			spy  = qmul(p[3], p[6]);
			sq   = qadd(qmul(spx, spx), qmul(spy, spy));
			gain = qsub(FX_ONE, qmul(p[7], qadd(FX_ONE, sq >>> 1)));
			r.coord[0] = qadd(p[0], qmul(spx, sh_len));
			r.coord[1] = qadd(p[1], qmul(spy, sh_len));
			r.coord[2] = qadd(p[4], qmul(sh_len, gain));
			r.coord[3] = qadd(p[5], sh_len);
		end else begin
			opd = qadd(FX_ONE, p[8]);
			arg = qsub(qsub(qmul(opd, opd), qmul(p[2], p[2])), qmul(p[3], p[3]));
			if (arg <= 0) begin
				r.lost = 1'b1;
			end else begin
				lpz = qdiv(sh_len, qsqrt(arg));
				b2  = qmul(sh_beta, sh_beta);
				lbz = qmul(qadd(qmul(b2, p[9]), FX_ONE), lpz);
				r.coord[0] = qadd(p[0], qmul(p[2], lpz));
				r.coord[1] = qadd(p[1], qmul(p[3], lpz));
				r.coord[2] = qadd(p[4], qsub(sh_len, lbz));
				r.coord[3] = qadd(p[5], sh_len);
			end
		end
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic word_t rnd_word();
		return {$urandom, $urandom};
	endfunction

	// signed random value of magnitude at most 2^bits
	function automatic word_t rnd_near(int bits);
		return rnd_word() >>> (63 - bits);
	endfunction

	function automatic word_t rnd_edge();
		case ($urandom_range(4))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return '1;
			default: return rnd_word();
		endcase
	endfunction

	// mostly a plausible particle, sometimes with wild fields mixed in
	function automatic particle_t rnd_particle();
		particle_t p;
		bit noisy;
		noisy = ($urandom_range(99) < 15);
		p[0] = rnd_near(36);
		p[1] = rnd_near(36);
		p[2] = rnd_near(30);
		p[3] = rnd_near(30);
		p[4] = rnd_near(36);
		p[5] = rnd_near(50);
		p[6] = FX_ONE + rnd_near(30);
		p[7] = FX_ONE + rnd_near(30);
		p[8] = rnd_near(32);
		p[9] = rnd_near(32);
		if (noisy)
			foreach (p[k]) if ($urandom_range(3) == 0) p[k] = rnd_edge();
		return p;
	endfunction

	task automatic add_row(logic mode, word_t len, word_t beta, particle_t p,
	                       bit typed = 1'b0, logic lost = 1'b0);
		stim_rows.push_back('{mode, len, beta, p, typed, lost});
	endtask

	task automatic report_mismatch(string what, word_t got, word_t want);
		errors++;
		$display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	// drop the input, hold until every expected result has arrived, then let the pipe go quiet
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_drifts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MODE:   sh_mode = data[0];
			REG_LENGTH: sh_len  = {1'b0, data[LEN_W-1:0]};
			REG_BETA:   sh_beta = {{(W-BETA_W){1'b0}}, data[BETA_W-1:0]};
			default: ;
		endcase
	endtask

	// write all three registers, with junk in the bits above each field
	task automatic set_drift(logic mode, word_t len, word_t beta);
		write_reg(REG_MODE, (rnd_word() << 1) | W'(mode));
		write_reg(REG_LENGTH, {1'($urandom_range(1)), len[LEN_W-1:0]});
		write_reg(REG_BETA, (rnd_word() << BETA_W) | W'(beta[BETA_W-1:0]));
	endtask

	// offer one particle and record what it must produce once it is taken
	task automatic send_particle(particle_t p, bit typed, logic lost);
		drift_result_t   exp_r;
		int              gap;
		logic [10*W-1:0] flat;
		gap = no_gaps ? 0 : $urandom_range(5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		foreach (p[k]) flat[k*W +: W] = p[k];
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= flat;
		do @(posedge clk); while (!s_axis_tready);
		if (typed) begin
			exp_r.coord = '{p[0], p[1], p[4], p[5]};
			exp_r.lost  = lost;
		end else begin
			exp_r = drift_particle(p);
		end
		pending_drifts.push_back(exp_r);
		items_sent++;
	endtask

	// ---------------- receiver ----------------

	initial begin : receiver
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				// long hold-off: the pipe fills and must back-pressure its input
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = no_gaps ? 0 : $urandom_range(5);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// ---------------- result checker ----------------

	always @(posedge clk) begin
		drift_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_drifts.size() == 0) begin
				errors++;
				$display("ERROR %0t: result with no particle outstanding", $realtime);
			end else begin
				want = pending_drifts.pop_front();
				results_seen++;
				if (m_axis_tuser) lost_seen++;
				for (int k = 0; k < 4; k++)
					if (m_axis_tdata[k*W +: W] !== want.coord[k])
						report_mismatch($sformatf("coordinate %0d", k),
						                m_axis_tdata[k*W +: W], want.coord[k]);
				if (m_axis_tuser !== want.lost)
					report_mismatch("lost flag", word_t'(m_axis_tuser), word_t'(want.lost));
			end
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_drifts.size());
			$display("particle_drift_step: mismatch");
			$finish;
		end
	end

	// ---------------- main sequence ----------------

	initial begin : stimulus
		particle_t p, q;
		logic  ph_mode;
		word_t ph_len, ph_beta;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; at reset the length is zero, so coordinates pass straight through
		p = '{default: '0};
		add_row(MODE_EXPANDED, '0, FX_ONE, p, 1'b1, 1'b0);
		p = '{default: S_MAX};
		add_row(MODE_EXPANDED, '0, FX_ONE, p, 1'b1, 1'b0);
		p = '{default: S_MIN};
		add_row(MODE_EXPANDED, '0, FX_ONE, p, 1'b1, 1'b0);
		p = '{default: '1};
		add_row(MODE_EXPANDED, '0, FX_ONE, p, 1'b1, 1'b0);
		foreach (p[k]) p[k] = k[0] ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555;
		add_row(MODE_EXPANDED, '0, FX_ONE, p, 1'b1, 1'b0);
		// exact mode: zero root argument and a huge transverse momentum are both lost
		p = '{default: '0};
		p[0] = 64'sd123; p[1] = -64'sd77; p[4] = 64'sd5; p[5] = 64'sd9;
		p[8] = -FX_ONE;
		add_row(MODE_EXACT, FX_ONE, FX_ONE, p, 1'b1, 1'b1);
		p[8] = '0; p[2] = S_MAX;
		add_row(MODE_EXACT, FX_ONE, FX_ONE, p, 1'b1, 1'b1);
		p[2] = '0; p[8] = S_MIN;
		add_row(MODE_EXACT, FX_ONE, FX_ONE, p);
		p[8] = S_MAX;
		add_row(MODE_EXACT, FX_ONE, FX_ONE, p);
		q = rnd_particle();
		add_row(MODE_EXACT, FX_ONE, FX_ONE, q);
		add_row(MODE_EXACT, LEN_MAX, '0, q);
		q[9] = S_MIN;
		add_row(MODE_EXACT, LEN_MAX, '0, q);
		add_row(MODE_EXACT, FX_ONE, BETA_ALL, q);
		q = rnd_particle();
		add_row(MODE_EXPANDED, LEN_MAX, FX_ONE, q);
		q[2] = S_MAX; q[6] = S_MAX;
		add_row(MODE_EXPANDED, LEN_MAX, FX_ONE, q);
		q[7] = S_MIN;
		add_row(MODE_EXPANDED, LEN_MAX, FX_ONE, q);
		q = rnd_particle();
		add_row(MODE_EXPANDED, FX_ONE, FX_ONE, q);
		q[6] = '0;
		add_row(MODE_EXPANDED, FX_ONE, FX_ONE, q);

		// an out-of-range index must leave every register alone
		write_reg(REG_UNUSED, rnd_word());
		foreach (stim_rows[i]) begin
			if (stim_rows[i].mode != sh_mode || stim_rows[i].len != sh_len ||
			    stim_rows[i].beta != sh_beta) begin
				drain();
				set_drift(stim_rows[i].mode, stim_rows[i].len, stim_rows[i].beta);
			end
			send_particle(stim_rows[i].p, stim_rows[i].typed, stim_rows[i].lost);
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();	// sender pauses until the pipe is empty
			ph_mode = ph[0];
			case (ph % 5)
				0: ph_len = '0;
				1: ph_len = LEN_MAX;
				2: ph_len = FX_ONE;
				3: ph_len = word_t'($urandom_range(4 << 16)) << 24;
				default: ph_len = rnd_word() >> 1;
			endcase
			case (ph % 4)
				0: ph_beta = FX_ONE;
				1: ph_beta = '0;
				2: ph_beta = BETA_ALL;
				default: ph_beta = rnd_word() >> (W - BETA_W);
			endcase
			set_drift(ph_mode, ph_len, ph_beta);
			write_reg(REG_UNUSED, rnd_word());
			no_gaps = (ph % 4 == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 40) hold_req = 1'b1;
				send_particle(rnd_particle(), 1'b0, 1'b0);
			end
		end
		no_gaps = 1'b0;

		drain();
		$display("sent %0d particles, checked %0d results (%0d lost)",
		         items_sent, results_seen, lost_seen);
		$display("covered both drift modes, length and beta extremes, back-pressure stretch");
		if (errors == 0 && pending_drifts.size() == 0)
			$display("particle_drift_step: match");
		else
			$display("particle_drift_step: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
src/pds_pkg.sv
src/pds_mul.sv
src/pds_sqrt.sv
src/pds_div.sv
src/particle_drift_step.sv
verif/tb_particle_drift_step.sv
